// File: sv/cursor_line_editor_buffer_defines.svh
// Assertion macros used by the line editor top level.
`ifndef CURSOR_LINE_EDITOR_BUFFER_DEFINES_SVH
`define CURSOR_LINE_EDITOR_BUFFER_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition implies consequence in the same cycle.
`define CLEB_ASSERT_IMPLY(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Condition implies consequence in the next cycle.
`define CLEB_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`else

`define CLEB_ASSERT_IMPLY(lbl, clk, rst_n, cond, cons)
`define CLEB_ASSERT_NEXT(lbl, clk, rst_n, cond, cons)

`endif

`endif

// File: sv/cleb_pkg.sv
`timescale 1ns / 1ps

package cleb_pkg;

    // Default line capacity in characters.
    localparam int LINE_DEPTH_DEF = 64;

    // Item opcodes.
    localparam logic OP_KEY   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Editing keys.
    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_BACK  = 8'h2D;

    // Write enables of the two stack memories.
    typedef struct packed {
        logic bef_we;
        logic aft_we;
    } cleb_wen_t;

endpackage

// File: sv/cleb_if.sv
`timescale 1ns / 1ps

// Key and flush items into the editor.
interface cleb_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

// Characters of a flushed line out of the editor.
interface cleb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;
    logic       empty_res;

    modport source (output valid, output out_char, output last, output empty_res,
                    input ready);
    modport sink   (input valid, input out_char, input last, input empty_res,
                    output ready);
endinterface

// File: sv/cleb_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module cleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/cleb_ctrl.sv
`timescale 1ns / 1ps

// Editor control: stack counts, key decode, memory sequencing and flush walk.
module cleb_ctrl
    import cleb_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cleb_in_if.sink                       in_ch,
    cleb_out_if.source                    out_ch,
    output cleb_wen_t                     wen,
    output logic [$clog2(LINE_DEPTH)-1:0] bef_waddr,
    output logic [7:0]                    bef_wdata,
    output logic [$clog2(LINE_DEPTH)-1:0] bef_raddr,
    input  logic [7:0]                    bef_rdata,
    output logic [$clog2(LINE_DEPTH)-1:0] aft_waddr,
    output logic [7:0]                    aft_wdata,
    output logic [$clog2(LINE_DEPTH)-1:0] aft_raddr,
    input  logic [7:0]                    aft_rdata
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MOVE_L = 3'd1;
    localparam logic [2:0] ST_MOVE_R = 3'd2;
    localparam logic [2:0] ST_FL_RD  = 3'd3;
    localparam logic [2:0] ST_FL_WB  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] bc_reg, bc_next;
    logic [CW-1:0] ac_reg, ac_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          src_aft_reg, src_aft_next;
    logic          last_pend_reg, last_pend_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic          out_last_reg, out_last_next;
    logic          out_empty_reg, out_empty_next;

    logic          accept;
    logic          out_free;
    logic          load_out;
    logic [CW-1:0] total;
    logic          is_left;
    logic          is_right;
    logic          is_back;
    logic          left_ok;
    logic          right_ok;
    logic          ins_ok;

    // Handshake and key decode.
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign total       = CW'(bc_reg + ac_reg);
    assign is_left     = (in_ch.key == KEY_LEFT);
    assign is_right    = (in_ch.key == KEY_RIGHT);
    assign is_back     = (in_ch.key == KEY_BACK);
    assign left_ok     = (bc_reg != '0) && (ac_reg < DEPTH_C);
    assign right_ok    = (ac_reg != '0) && (bc_reg < DEPTH_C);
    assign ins_ok      = (total < DEPTH_C);

    // Read addresses: stack tops for moves, walk position during a flush.
    assign bef_raddr = (state_reg == ST_FL_RD) ? AW'(pos_reg) : AW'(bc_reg - ONE_C);
    assign aft_raddr = (state_reg == ST_FL_RD) ? AW'(total - ONE_C - pos_reg)
                                               : AW'(ac_reg - ONE_C);

    // Writes: an insert or a right move pushes the before stack, a left move the after one.
    assign wen.bef_we = (accept && (in_ch.op == OP_KEY) && !is_left && !is_right
                         && !is_back && ins_ok) || (state_reg == ST_MOVE_R);
    assign wen.aft_we = (state_reg == ST_MOVE_L);
    assign bef_waddr  = AW'(bc_reg);
    assign bef_wdata  = (state_reg == ST_MOVE_R) ? aft_rdata : in_ch.key;
    assign aft_waddr  = AW'(ac_reg);
    assign aft_wdata  = bef_rdata;

    // Next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        bc_next        = bc_reg;
        ac_next        = ac_reg;
        pos_next       = pos_reg;
        src_aft_next   = src_aft_reg;
        last_pend_next = last_pend_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        load_out       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.op == OP_FLUSH)
                    begin
                        pos_next   = '0;
                        state_next = ST_FL_RD;
                    end
                    else if (is_left)
                    begin
                        if (left_ok)
                        begin
                            state_next = ST_MOVE_L;
                        end
                    end
                    else if (is_right)
                    begin
                        if (right_ok)
                        begin
                            state_next = ST_MOVE_R;
                        end
                    end
                    else if (is_back)
                    begin
                        if (bc_reg != '0)
                        begin
                            bc_next = bc_reg - ONE_C;
                        end
                    end
                    else if (ins_ok)
                    begin
                        bc_next = bc_reg + ONE_C;
                    end
                end
            end
            ST_MOVE_L:
            begin
                bc_next    = bc_reg - ONE_C;
                ac_next    = ac_reg + ONE_C;
                state_next = ST_IDLE;
            end
            ST_MOVE_R:
            begin
                ac_next    = ac_reg - ONE_C;
                bc_next    = bc_reg + ONE_C;
                state_next = ST_IDLE;
            end
            ST_FL_RD:
            begin
                if (out_free)
                begin
                    if (total == '0)
                    begin
                        // An empty line gives one marked result.
                        load_out       = 1'b1;
                        out_char_next  = '0;
                        out_last_next  = 1'b1;
                        out_empty_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        src_aft_next   = (pos_reg >= bc_reg);
                        last_pend_next = (pos_reg == total - ONE_C);
                        state_next     = ST_FL_WB;
                    end
                end
            end
            ST_FL_WB:
            begin
                // The output register is known to be empty here.
                load_out       = 1'b1;
                out_char_next  = src_aft_reg ? aft_rdata : bef_rdata;
                out_last_next  = last_pend_reg;
                out_empty_next = 1'b0;
                if (last_pend_reg)
                begin
                    bc_next    = '0;
                    ac_next    = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next   = pos_reg + ONE_C;
                    state_next = ST_FL_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bc_reg        <= '0;
            ac_reg        <= '0;
            pos_reg       <= '0;
            src_aft_reg   <= 1'b0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bc_reg        <= bc_next;
            ac_reg        <= ac_next;
            pos_reg       <= pos_next;
            src_aft_reg   <= src_aft_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_char  = out_char_reg;
    assign out_ch.last      = out_last_reg;
    assign out_ch.empty_res = out_empty_reg;

endmodule

// File: sv/cursor_line_editor_buffer.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                      Meaning
// in_ch     sink       op, key                      key stroke or flush request
// out_ch    source     out_char, last, empty_res    one character of a flushed line
//
// Insert and backspace complete as the item is taken; a cursor move also passes
// through a move state, since the top of one stack memory is read and then written
// to the other stack. A flush reads each character from its stack and then loads it
// into the output register; an empty line gives a single result.
// Reset clears both counts; the memories need no clearing pass.
// A stalled output holds the flush walk; the last result may wait while new
// items are taken.
`include "cursor_line_editor_buffer_defines.svh"

module cursor_line_editor_buffer
    import cleb_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cleb_in_if.sink    in_ch,
    cleb_out_if.source out_ch
);

    localparam int AW = $clog2(LINE_DEPTH);

    cleb_wen_t       wen;
    logic [AW-1:0]   bef_waddr;
    logic [7:0]      bef_wdata;
    logic [AW-1:0]   bef_raddr;
    logic [7:0]      bef_rdata;
    logic [AW-1:0]   aft_waddr;
    logic [7:0]      aft_wdata;
    logic [AW-1:0]   aft_raddr;
    logic [7:0]      aft_rdata;

    // Stack of characters before the cursor.
    cleb_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_bef_ram (
        .clk   (clk),
        .we    (wen.bef_we),
        .waddr (bef_waddr),
        .wdata (bef_wdata),
        .raddr (bef_raddr),
        .rdata (bef_rdata)
    );

    // Stack of characters after the cursor.
    cleb_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_aft_ram (
        .clk   (clk),
        .we    (wen.aft_we),
        .waddr (aft_waddr),
        .wdata (aft_wdata),
        .raddr (aft_raddr),
        .rdata (aft_rdata)
    );

    // Control and flush sequencing.
    cleb_ctrl #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .wen       (wen),
        .bef_waddr (bef_waddr),
        .bef_wdata (bef_wdata),
        .bef_raddr (bef_raddr),
        .bef_rdata (bef_rdata),
        .aft_waddr (aft_waddr),
        .aft_wdata (aft_wdata),
        .aft_raddr (aft_raddr),
        .aft_rdata (aft_rdata)
    );

    // At most one stack is written in any cycle.
    `CLEB_ASSERT_IMPLY(a_one_stack_write, clk, rst_n, 1'b1, $onehot0(wen))
    // An accepted flush blocks the input while the line is walked.
    `CLEB_ASSERT_NEXT(a_flush_blocks, clk, rst_n, in_ch.valid && in_ch.ready && (in_ch.op == OP_FLUSH), !in_ch.ready)
    // An empty-line result is always the final one.
    `CLEB_ASSERT_IMPLY(a_empty_is_last, clk, rst_n, out_ch.valid && out_ch.empty_res, out_ch.last)
    // No write to a stack happens while a flush is being walked out.
    `CLEB_ASSERT_IMPLY(a_no_write_in_flush, clk, rst_n, !in_ch.ready && !$past(in_ch.ready) && !$past(in_ch.ready, 2), !wen.bef_we && !wen.aft_we)

endmodule
